// ----- design/tch_pkg.sv -----
// ----------------------------------------------------------------------------
// tch_pkg: shared constants and types for the tilt-compensated heading block
// Angle formats, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package tch_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int STAGES_USED   = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

   localparam int ANG_W   = 28;   // degree * 2^16, covers +-2^27
   localparam int SC_W    = 27;   // Q24 sine / cosine with CORDIC growth
   localparam int VEC_W   = 48;   // horizontal vector, Q24 * 16-bit counts
   localparam int DECL_W  = 13;
   localparam int HEAD_W  = 16;
   localparam int STAGE_W = 5;

   localparam logic signed [16:0] HALF_TURN    = 17'sd23040;
   localparam logic signed [16:0] FULL_TURN    = 17'sd46080;
   localparam logic signed [16:0] QUARTER_TURN = 17'sd11520;
   localparam logic signed [SC_W-1:0] GAIN_Q24 = 27'sd10187014;
   localparam logic signed [ANG_W-1:0] HALF_TURN_FINE = 28'sd11796480;
   localparam logic signed [DECL_W-1:0] DECL_RESET = 13'sd1408;

   typedef logic signed [SC_W-1:0]  sc_type;
   typedef logic signed [ANG_W-1:0] ang_type;
   typedef logic signed [VEC_W-1:0] vec_type;

   // Both rotations of one item travel together through the first cell row.
   typedef struct packed {
      sc_type  px;
      sc_type  py;
      ang_type pz;
      logic    pneg;
      sc_type  rx;
      sc_type  ry;
      ang_type rz;
      logic    rneg;
      logic signed [15:0] fx;
      logic signed [15:0] fy;
      logic signed [15:0] fz;
   } rot_type;

   typedef struct packed {
      vec_type x;
      vec_type y;
      ang_type z;
      logic    zero;
   } vecc_type;

   function automatic ang_type atan_entry(input logic [STAGE_W-1:0] i);
      case (i)
         5'd0:  atan_entry = 28'sd2949120;
         5'd1:  atan_entry = 28'sd1740967;
         5'd2:  atan_entry = 28'sd919879;
         5'd3:  atan_entry = 28'sd466945;
         5'd4:  atan_entry = 28'sd234379;
         5'd5:  atan_entry = 28'sd117304;
         5'd6:  atan_entry = 28'sd58666;
         5'd7:  atan_entry = 28'sd29335;
         5'd8:  atan_entry = 28'sd14668;
         5'd9:  atan_entry = 28'sd7334;
         5'd10: atan_entry = 28'sd3667;
         5'd11: atan_entry = 28'sd1833;
         5'd12: atan_entry = 28'sd917;
         5'd13: atan_entry = 28'sd458;
         5'd14: atan_entry = 28'sd229;
         5'd15: atan_entry = 28'sd115;
         5'd16: atan_entry = 28'sd57;
         5'd17: atan_entry = 28'sd29;
         5'd18: atan_entry = 28'sd14;
         5'd19: atan_entry = 28'sd7;
         5'd20: atan_entry = 28'sd4;
         5'd21: atan_entry = 28'sd2;
         5'd22: atan_entry = 28'sd1;
         default: atan_entry = 28'sd0;
      endcase
   endfunction

endpackage

// ----- design/tch_rot_cell.sv -----
// ----------------------------------------------------------------------------
// tch_rot_cell: one CORDIC rotation step for pitch and roll
// Applies micro-rotation I to both angle paths and registers the result.
// ----------------------------------------------------------------------------
module tch_rot_cell (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [tch_pkg::STAGE_W-1:0]        stage,
   input  tch_pkg::rot_type                   in_data,
   output tch_pkg::rot_type                   out_data
);

   tch_pkg::rot_type data_ff, data_in;
   tch_pkg::ang_type step;

   always_comb begin
      step    = tch_pkg::atan_entry(stage);
      data_in = in_data;
      if (!in_data.pz[tch_pkg::ANG_W-1]) begin
         data_in.px = in_data.px - (in_data.py >>> stage);
         data_in.py = in_data.py + (in_data.px >>> stage);
         data_in.pz = in_data.pz - step;
      end else begin
         data_in.px = in_data.px + (in_data.py >>> stage);
         data_in.py = in_data.py - (in_data.px >>> stage);
         data_in.pz = in_data.pz + step;
      end
      if (!in_data.rz[tch_pkg::ANG_W-1]) begin
         data_in.rx = in_data.rx - (in_data.ry >>> stage);
         data_in.ry = in_data.ry + (in_data.rx >>> stage);
         data_in.rz = in_data.rz - step;
      end else begin
         data_in.rx = in_data.rx + (in_data.ry >>> stage);
         data_in.ry = in_data.ry - (in_data.rx >>> stage);
         data_in.rz = in_data.rz + step;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_data = data_ff;

endmodule

// ----- design/tch_vec_cell.sv -----
// ----------------------------------------------------------------------------
// tch_vec_cell: one CORDIC vectoring step for the horizontal field vector
// Drives Y toward zero and accumulates the angle.
// ----------------------------------------------------------------------------
module tch_vec_cell (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [tch_pkg::STAGE_W-1:0]        stage,
   input  tch_pkg::vecc_type                  in_data,
   output tch_pkg::vecc_type                  out_data
);

   tch_pkg::vecc_type data_ff, data_in;
   tch_pkg::ang_type  step;

   always_comb begin
      step    = tch_pkg::atan_entry(stage);
      data_in = in_data;
      if (!in_data.y[tch_pkg::VEC_W-1]) begin
         data_in.x = in_data.x + (in_data.y >>> stage);
         data_in.y = in_data.y - (in_data.x >>> stage);
         data_in.z = in_data.z + step;
      end else begin
         data_in.x = in_data.x - (in_data.y >>> stage);
         data_in.y = in_data.y + (in_data.x >>> stage);
         data_in.z = in_data.z - step;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_data = data_ff;

endmodule

// ----- design/tilt_compensated_heading.sv -----
// ----------------------------------------------------------------------------
// tilt_compensated_heading: tilt-compensated compass heading pipeline
// Pitch/roll sine and cosine by CORDIC, horizontal projection, atan2 by CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries pitch, roll (1/128 degree) and the magnetometer
//    vector; a transfer happens when req_valid is high and req_stall is low.
//  - rsp_ channel returns heading_angle in 1/128 degree plus declination,
//    unwrapped; a transfer happens when rsp_valid is high and rsp_stall low.
//  - csr_write_enable loads csr_declination_offset; write only while idle.
//  - Throughput: one transfer per clock while the response is not stalled.
//    Every CORDIC step is one cell of a row and each cell hands its data to
//    the next one whenever the pipeline advances. Order from request to
//    response: rotation row, four product stages (signs, two multiplies,
//    sums), vectoring setup, vectoring row, round and add.
//  - A stalled response freezes the whole pipeline; req_stall is then high
//    only while the output register is held.
//  - Reset clears all valid bits and loads 11 degrees of declination.
// ----------------------------------------------------------------------------
module tilt_compensated_heading (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [15:0] req_field_x,
   input  logic signed [15:0] req_field_y,
   input  logic signed [15:0] req_field_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_heading_angle,
   input  logic               csr_write_enable,
   input  logic signed [12:0] csr_declination_offset
);

   localparam int NS    = tch_pkg::STAGES_USED;
   localparam int DEPTH = 2 * NS + 6;

   logic             adv;           // whole pipeline moves
   logic [DEPTH-1:0] valid_ff;
   logic signed [tch_pkg::DECL_W-1:0] decl_ff;

   assign adv       = !(valid_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         decl_ff  <= tch_pkg::DECL_RESET;
      end else begin
         if (adv) begin
            valid_ff <= {valid_ff[DEPTH-2:0], req_valid};
         end
         if (csr_write_enable) begin
            decl_ff <= csr_declination_offset;
         end
      end
   end

   // ---- angle reduction to +-90 degrees, start of rotation row ----
   function automatic logic signed [16:0] wrap_angle(input logic signed [15:0] a);
      logic signed [16:0] w;
      w = 17'(a);
      if (w >= tch_pkg::HALF_TURN) w = w - tch_pkg::FULL_TURN;
      if (w < -tch_pkg::HALF_TURN) w = w + tch_pkg::FULL_TURN;
      return w;
   endfunction

   logic signed [16:0] pw, rw, pf, rf;
   logic               pneg, rneg;
   tch_pkg::rot_type   rot_chain [NS+1];

   always_comb begin
      pw = wrap_angle(req_pitch_angle);
      rw = wrap_angle(req_roll_angle);
      pf = pw; pneg = 1'b0;
      rf = rw; rneg = 1'b0;
      if (pw > tch_pkg::QUARTER_TURN) begin
         pf = pw - tch_pkg::HALF_TURN; pneg = 1'b1;
      end
      if (pw < -tch_pkg::QUARTER_TURN) begin
         pf = pw + tch_pkg::HALF_TURN; pneg = 1'b1;
      end
      if (rw > tch_pkg::QUARTER_TURN) begin
         rf = rw - tch_pkg::HALF_TURN; rneg = 1'b1;
      end
      if (rw < -tch_pkg::QUARTER_TURN) begin
         rf = rw + tch_pkg::HALF_TURN; rneg = 1'b1;
      end
      rot_chain[0].px   = tch_pkg::GAIN_Q24;
      rot_chain[0].py   = '0;
      rot_chain[0].pz   = tch_pkg::ang_type'(pf) <<< 9;
      rot_chain[0].pneg = pneg;
      rot_chain[0].rx   = tch_pkg::GAIN_Q24;
      rot_chain[0].ry   = '0;
      rot_chain[0].rz   = tch_pkg::ang_type'(rf) <<< 9;
      rot_chain[0].rneg = rneg;
      rot_chain[0].fx   = req_field_x;
      rot_chain[0].fy   = req_field_y;
      rot_chain[0].fz   = req_field_z;
   end

   for (genvar g = 0; g < NS; g++) begin : g_rot
      tch_rot_cell u_cell (
         .clock    (clock),
         .enable   (adv),
         .stage    (tch_pkg::STAGE_W'(g)),
         .in_data  (rot_chain[g]),
         .out_data (rot_chain[g+1])
      );
   end

   // ---- stage M1: apply signs ----
   tch_pkg::rot_type  rend;
   tch_pkg::sc_type   cp_ff, sp_ff, cr_ff, sr_ff;
   logic signed [15:0] fx1_ff, fy1_ff, fz1_ff;
   assign rend = rot_chain[NS];

   always_ff @(posedge clock) begin
      if (adv) begin
         cp_ff  <= rend.pneg ? -rend.px : rend.px;
         sp_ff  <= rend.pneg ? -rend.py : rend.py;
         cr_ff  <= rend.rneg ? -rend.rx : rend.rx;
         sr_ff  <= rend.rneg ? -rend.ry : rend.ry;
         fx1_ff <= rend.fx;
         fy1_ff <= rend.fy;
         fz1_ff <= rend.fz;
      end
   end

   // ---- stage M2: sr*sp, sr*cp rounded to Q24 ----
   logic signed [53:0] ssp_full, scp_full;
   tch_pkg::sc_type    cp2_ff, sp2_ff, cr2_ff, ssp_ff, scp_ff;
   logic signed [15:0] fx2_ff, fy2_ff, fz2_ff;

   assign ssp_full = 54'(sr_ff) * 54'(sp_ff) + 54'sd8388608;
   assign scp_full = 54'(sr_ff) * 54'(cp_ff) + 54'sd8388608;

   always_ff @(posedge clock) begin
      if (adv) begin
         ssp_ff <= tch_pkg::sc_type'(ssp_full >>> 24);
         scp_ff <= tch_pkg::sc_type'(scp_full >>> 24);
         cp2_ff <= cp_ff;
         sp2_ff <= sp_ff;
         cr2_ff <= cr_ff;
         fx2_ff <= fx1_ff;
         fy2_ff <= fy1_ff;
         fz2_ff <= fz1_ff;
      end
   end

   // ---- stage M3: products with the field ----
   tch_pkg::vec_type a_ff, b_ff, c_ff, d_ff, e_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= tch_pkg::vec_type'(fx2_ff) * tch_pkg::vec_type'(cp2_ff);
         b_ff <= tch_pkg::vec_type'(fz2_ff) * tch_pkg::vec_type'(sp2_ff);
         c_ff <= tch_pkg::vec_type'(fx2_ff) * tch_pkg::vec_type'(ssp_ff);
         d_ff <= tch_pkg::vec_type'(fy2_ff) * tch_pkg::vec_type'(cr2_ff);
         e_ff <= tch_pkg::vec_type'(fz2_ff) * tch_pkg::vec_type'(scp_ff);
      end
   end

   // ---- stage M4: sums ----
   tch_pkg::vec_type xh_ff, yh_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         xh_ff <= a_ff - b_ff;
         yh_ff <= c_ff + d_ff + e_ff;
      end
   end

   // ---- stage M5: left half-plane fold, vectoring row ----
   tch_pkg::vecc_type vec_chain [NS+1];
   tch_pkg::vecc_type vstart_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         vstart_ff.zero <= (xh_ff == '0) && (yh_ff == '0);
         if (xh_ff[tch_pkg::VEC_W-1]) begin
            vstart_ff.x <= -xh_ff;
            vstart_ff.y <= -yh_ff;
            vstart_ff.z <= yh_ff[tch_pkg::VEC_W-1] ? -tch_pkg::HALF_TURN_FINE
                                                  : tch_pkg::HALF_TURN_FINE;
         end else begin
            vstart_ff.x <= xh_ff;
            vstart_ff.y <= yh_ff;
            vstart_ff.z <= '0;
         end
      end
   end

   assign vec_chain[0] = vstart_ff;

   for (genvar g = 0; g < NS; g++) begin : g_vec
      tch_vec_cell u_cell (
         .clock    (clock),
         .enable   (adv),
         .stage    (tch_pkg::STAGE_W'(g)),
         .in_data  (vec_chain[g]),
         .out_data (vec_chain[g+1])
      );
   end

   // ---- output register: round to 1/128 degree, add declination ----
   tch_pkg::vecc_type  vend;
   tch_pkg::ang_type   zr;
   logic signed [15:0] heading_in, heading_ff;

   assign vend = vec_chain[NS];
   always_comb begin
      zr         = (vend.z + tch_pkg::ang_type'(256)) >>> 9;
      heading_in = vend.zero ? 16'(decl_ff) : 16'(zr) + 16'(decl_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         heading_ff <= heading_in;
      end
   end

   assign rsp_valid         = valid_ff[DEPTH-1];
   assign rsp_heading_angle = heading_ff;

`ifndef NO_ASSERTIONS
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked output");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_heading_angle)))
      else $error("output changed while stalled");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the tilt-compensated heading pipeline
// Drives pitch, roll and field samples, predicts each heading with a
// bit-exact integer CORDIC model and checks every response in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int LATENCY   = 2 * tch_pkg::STAGES_USED + 6;
   localparam int LIMIT     = 400000;
   localparam int N_RANDOM  = 1600;

   typedef struct packed {
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
      logic signed [15:0] fx;
      logic signed [15:0] fy;
      logic signed [15:0] fz;
   } sample_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_pitch_angle = '0;
   logic signed [15:0] req_roll_angle = '0;
   logic signed [15:0] req_field_x = '0;
   logic signed [15:0] req_field_y = '0;
   logic signed [15:0] req_field_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_heading_angle;
   logic               csr_write_enable = 1'b0;
   logic signed [12:0] csr_declination_offset = '0;

   tilt_compensated_heading u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_pitch_angle        (req_pitch_angle),
      .req_roll_angle         (req_roll_angle),
      .req_field_x            (req_field_x),
      .req_field_y            (req_field_y),
      .req_field_z            (req_field_z),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_heading_angle      (rsp_heading_angle),
      .csr_write_enable       (csr_write_enable),
      .csr_declination_offset (csr_declination_offset)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model's copy of the declination register.
   longint     decl_model = 1408;
   sample_type pending_samples[$];
   logic signed [15:0] heading_queue[$];
   int         idle_pct = 0;     // sender gap odds, percent
   int         stall_pct = 0;    // receiver stall odds, percent
   int         mismatches = 0;
   int         checked = 0;
   longint     cycles = 0;
   bit         req_fire = 1'b0;  // input transfer at the last rising edge

   // ---------------------------------------------------------------- model
   function automatic longint atan_deg16(int i);
      longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                          58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                          229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
      return tab[i];
   endfunction

   // >>> on a signed longint is an arithmetic (floor) shift
   function automatic longint rnd_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   // angle in 1/128 degree -> Q24 cosine and sine
   function automatic void rotate_unit(input longint a, output longint c,
                                       output longint s);
      longint x, y, z, dx, dy;
      bit     flip;
      x = 10187014; y = 0; flip = 1'b0;
      if (a >= 23040) a -= 46080;
      if (a < -23040) a += 46080;
      // fold beyond a quarter turn, negate afterwards
      if (a > 11520) begin a -= 23040; flip = 1'b1; end
      if (a < -11520) begin a += 23040; flip = 1'b1; end
      z = a * 512;
      for (int i = 0; i < tch_pkg::STAGES_USED; i++) begin
         dx = y >>> i; dy = x >>> i;
         if (z >= 0) begin x -= dx; y += dy; z -= atan_deg16(i); end
         else begin x += dx; y -= dy; z += atan_deg16(i); end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // atan2 in degree * 2^16
   function automatic longint vector_angle(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 180 * 65536 : -180 * 65536;
         x = -x; y = -y;
      end
      for (int i = 0; i < tch_pkg::STAGES_USED; i++) begin
         dx = y >>> i; dy = x >>> i;
         if (y >= 0) begin x += dx; y -= dy; z += atan_deg16(i); end
         else begin x -= dx; y += dy; z -= atan_deg16(i); end
      end
      return z;
   endfunction

   function automatic logic signed [15:0] predict_heading(sample_type s);
      longint cp, sp, cr, sr, xh, yh, h;
      rotate_unit(s.pitch, cp, sp);
      rotate_unit(s.roll, cr, sr);
      xh = s.fx * cp - s.fz * sp;
      yh = s.fx * rnd_shift(sr * sp, 24) + s.fy * cr + s.fz * rnd_shift(sr * cp, 24);
      h  = rnd_shift(vector_angle(xh, yh), 9) + decl_model;
      return h[15:0];
   endfunction

   // ---------------------------------------------------------------- driver
   // Inputs change on the falling edge; a held item stays put while stalled.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_fire) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= idle_pct) begin
               sample_type s;
               s = pending_samples.pop_front();
               req_valid       <= 1'b1;
               req_pitch_angle <= s.pitch;
               req_roll_angle  <= s.roll;
               req_field_x     <= s.fx;
               req_field_y     <= s.fy;
               req_field_z     <= s.fz;
               heading_queue.push_back(predict_heading(s));
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      cycles   <= cycles + 1;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (heading_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response transfer: heading %0d", rsp_heading_angle);
         end else begin
            logic signed [15:0] want;
            want = heading_queue.pop_front();
            checked++;
            if (want !== rsp_heading_angle) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("heading mismatch: expected %0d got %0d", want, rsp_heading_angle);
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycles,
                  heading_queue.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic logic signed [15:0] rand_angle();
      case ($urandom_range(5))
         0:       return 16'($urandom);                          // any code
         1:       return 16'(int'($urandom_range(46080)) - 23040);
         2:       return 16'(int'($urandom_range(40)) + 11500);   // near fold
         3:       return 16'(int'($urandom_range(40)) - 11540);
         default: return 16'(int'($urandom_range(7680)) - 3840); // modest tilt
      endcase
   endfunction

   function automatic sample_type rand_sample();
      sample_type s;
      s.pitch = rand_angle();
      s.roll  = rand_angle();
      s.fx    = 16'($urandom);
      s.fy    = 16'($urandom);
      s.fz    = 16'($urandom);
      if ($urandom_range(9) == 0) s.fz = '0;
      if ($urandom_range(19) == 0) begin s.fx = '0; s.fy = '0; s.fz = '0; end
      return s;
   endfunction

   function automatic sample_type mk(int p, int r, int x, int y, int z);
      sample_type s;
      s.pitch = 16'(p); s.roll = 16'(r); s.fx = 16'(x); s.fy = 16'(y); s.fz = 16'(z);
      return s;
   endfunction

   // Wait for the pipeline to drain completely before touching the register.
   task automatic drain();
      while (pending_samples.size() > 0 || heading_queue.size() > 0 || req_valid)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_declination(logic signed [12:0] v);
      @(negedge clock);
      csr_write_enable       <= 1'b1;
      csr_declination_offset <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      decl_model = v;
   endtask

   initial begin
      logic signed [12:0] decl_set[6];
      decl_set = '{-13'sd3840, 13'sd3840, 13'sd0, 13'sb1_0000_0000_0000, 13'sd4095,
                   13'sd1408};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset declination, extremes, folds, wraps, zero vector,
      // negative Xh on both sides of the axis
      pending_samples.push_back(mk(0, 0, 1000, 0, 0));
      pending_samples.push_back(mk(0, 0, 0, 0, 0));
      pending_samples.push_back(mk(0, 0, -1000, 1, 0));
      pending_samples.push_back(mk(0, 0, -1000, -1, 0));
      pending_samples.push_back(mk(0, 0, -1000, 0, 0));
      pending_samples.push_back(mk(0, 0, 0, 1000, 0));
      pending_samples.push_back(mk(0, 0, 0, -1000, 0));
      pending_samples.push_back(mk(32767, -32768, 32767, 32767, 32767));
      pending_samples.push_back(mk(-32768, 32767, -32768, -32768, -32768));
      pending_samples.push_back(mk(23040, -23040, 500, 300, 200));
      pending_samples.push_back(mk(23039, -23041, 500, -300, 200));
      pending_samples.push_back(mk(11520, 11521, 700, 100, -900));
      pending_samples.push_back(mk(-11520, -11521, 700, 100, -900));
      pending_samples.push_back(mk(46080, -46080, 1, 2, 3));
      pending_samples.push_back(mk(5000, -7000, 32767, -32768, 32767));
      pending_samples.push_back(mk(-1, 1, -32768, 32767, -32768));
      drain();

      // random phases: declination settings crossed with idle/stall modes
      for (int ph = 0; ph < 6; ph++) begin
         write_declination(decl_set[ph]);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 64; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 64; end
            default: begin idle_pct = 13; stall_pct = 13; end
         endcase
         for (int n = 0; n < N_RANDOM / 6; n++)
            pending_samples.push_back(rand_sample());
         drain();
      end

      $display("checked %0d headings over six declination settings", checked);
      $display("idle/stall modes: none, sender 64%%, receiver 64%%, both 13%%");
      if (mismatches == 0 && heading_queue.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
design/tch_pkg.sv
design/tch_rot_cell.sv
design/tch_vec_cell.sv
design/tilt_compensated_heading.sv
tb/tb_top.sv
